/* src/lcdseq_pkg.sv */
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Shared types, codes and constants of the character LCD write sequencer.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

    localparam int TICK_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int NIBBLE_W   = 4;
    localparam int CMD_W      = 2;
    localparam int COL_W      = 5;
    localparam int IDX_W      = 3;

    // Request kinds.
    localparam logic [CMD_W-1:0] CMD_INIT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BYTE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CURSOR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TEXT   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_SETUP   = 2'd0;
    localparam logic [1:0] REG_PULSE   = 2'd1;
    localparam logic [1:0] REG_CMD_SET = 2'd2;
    localparam logic [1:0] REG_DAT_SET = 2'd3;

    localparam logic [TICK_W-1:0] SETUP_RESET   = 16'd10;
    localparam logic [TICK_W-1:0] PULSE_RESET   = 16'd200;
    localparam logic [TICK_W-1:0] CMD_SET_RESET = 16'd8000;
    localparam logic [TICK_W-1:0] DAT_SET_RESET = 16'd20;

    localparam logic [COL_W-1:0]  WRAP_COLUMN         = 5'd16;
    localparam logic [BYTE_W-1:0] SECOND_LINE_ADDRESS = 8'h40;
    localparam logic [BYTE_W-1:0] CURSOR_CMD          = 8'h80;

    localparam int INIT_COUNT = 6;

    // Pin states within one byte.
    localparam logic [IDX_W-1:0] PIN_HI_SETUP = 3'd0;
    localparam logic [IDX_W-1:0] PIN_HI_PULSE = 3'd1;
    localparam logic [IDX_W-1:0] PIN_HI_DROP  = 3'd2;
    localparam logic [IDX_W-1:0] PIN_LO_SETUP = 3'd3;
    localparam logic [IDX_W-1:0] PIN_LO_PULSE = 3'd4;
    localparam logic [IDX_W-1:0] PIN_LO_SETTLE = 3'd5;

    typedef struct packed {
        logic             load;
        logic             emit;
        logic             last;
        logic [IDX_W-1:0] byte_idx;
        logic [IDX_W-1:0] pin_idx;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic is_init;
        logic wrap;
    } dp_status_t;

    function automatic logic [BYTE_W-1:0] init_byte(input logic [IDX_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        begin
            case (idx)
                3'd0:    b = 8'h33;
                3'd1:    b = 8'h32;
                3'd2:    b = 8'h28;
                3'd3:    b = 8'h0D;
                3'd4:    b = 8'h1C;
                3'd5:    b = 8'h01;
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

endpackage

/* src/char_lcd_nibble_write_sequencer.sv */
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// Turns LCD requests into timed pin states for a 4-bit character LCD bus.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  s_axis    in         tdata: byte_value, text_start; tuser: command
//  m_axis    out        tdata: data_nibble, read_write, enable, hold_ticks;
//                       tuser: reg_select; tlast: last
//  apb       in/out     four 16-bit timing registers at 0x0, 0x4, 0x8, 0xC
//
// The sequencer takes a request, then emits one pin state per cycle while the
// output stage is free, walking the bytes of the request: one for a byte or
// cursor request, two for a character with a line wrap, six for init.
// Reset is synchronous and restores the register defaults and clears the text
// column. A stalled output holds the sequencer in place.
module char_lcd_nibble_write_sequencer
    import lcdseq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] byte_value, [8] text_start, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [3:0] data_nibble, [4] read_write,
                                   // [5] enable, [21:6] hold_ticks, rest zero
    output logic [0:0]  m_tuser,   // [0] reg_select
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [TICK_W-1:0]   setup_reg, pulse_reg, cmd_set_reg, dat_set_reg;
    logic                cfg_write;
    logic [1:0]          cfg_idx;
    ctrl_cmd_t           cmd;
    dp_status_t          status;
    logic [NIBBLE_W-1:0] nibble;
    logic                rs;
    logic                enable;
    logic [TICK_W-1:0]   hold;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setup_reg   <= SETUP_RESET;
            pulse_reg   <= PULSE_RESET;
            cmd_set_reg <= CMD_SET_RESET;
            dat_set_reg <= DAT_SET_RESET;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_SETUP:   setup_reg   <= pwdata[TICK_W-1:0];
                REG_PULSE:   pulse_reg   <= pwdata[TICK_W-1:0];
                REG_CMD_SET: cmd_set_reg <= pwdata[TICK_W-1:0];
                REG_DAT_SET: dat_set_reg <= pwdata[TICK_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SETUP:   prdata = {16'd0, setup_reg};
            REG_PULSE:   prdata = {16'd0, pulse_reg};
            REG_CMD_SET: prdata = {16'd0, cmd_set_reg};
            REG_DAT_SET: prdata = {16'd0, dat_set_reg};
            default:     prdata = '0;
        endcase
    end

    lcdseq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lcdseq_dpath u_dpath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .status               (status),
        .in_command           (s_tuser),
        .in_byte_value        (s_tdata[7:0]),
        .in_text_start        (s_tdata[8]),
        .setup_ticks          (setup_reg),
        .pulse_ticks          (pulse_reg),
        .command_settle_ticks (cmd_set_reg),
        .data_settle_ticks    (dat_set_reg),
        .out_ready            (m_tready),
        .out_valid            (m_tvalid),
        .out_nibble           (nibble),
        .out_rs               (rs),
        .out_enable           (enable),
        .out_hold             (hold),
        .out_last             (m_tlast)
    );

    assign m_tdata = {2'b00, hold, enable, 1'b0, nibble};
    assign m_tuser = rs;

    // A taken request keeps the input closed while its pin states go out.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted again right after a request");

    // The final pin state of a request always has enable low.
    a_last_enable_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> !m_tdata[5])
        else $error("final pin state with enable high");

    // Emitting never happens while the input side is open.
    a_no_emit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !s_tready)
        else $error("pin state emitted while idle");

endmodule

/* src/lcdseq_ctrl.sv */
// ----------------------------------------------------------------------------
// lcdseq_ctrl
// Sequencer state machine: takes a request, then walks bytes and pin states.
// ----------------------------------------------------------------------------
module lcdseq_ctrl
    import lcdseq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic             state_reg, state_next;
    logic [IDX_W-1:0] byte_reg, byte_next;
    logic [IDX_W-1:0] pin_reg, pin_next;
    logic             last_byte;

    always_comb begin
        if (status.is_init) begin
            last_byte = (byte_reg == IDX_W'(INIT_COUNT - 1));
        end else if (status.wrap) begin
            last_byte = (byte_reg == 3'd1);
        end else begin
            last_byte = (byte_reg == 3'd0);
        end
    end

    always_comb begin
        state_next   = state_reg;
        byte_next    = byte_reg;
        pin_next     = pin_reg;
        s_tready     = (state_reg == ST_IDLE);
        cmd.load     = 1'b0;
        cmd.emit     = 1'b0;
        cmd.last     = last_byte && (pin_reg == PIN_LO_SETTLE);
        cmd.byte_idx = byte_reg;
        cmd.pin_idx  = pin_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                    byte_next  = '0;
                    pin_next   = '0;
                end
            end
            ST_RUN: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (pin_reg == PIN_LO_SETTLE) begin
                        pin_next = '0;
                        if (last_byte) begin
                            state_next = ST_IDLE;
                        end else begin
                            byte_next = byte_reg + 3'd1;
                        end
                    end else begin
                        pin_next = pin_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            byte_reg  <= '0;
            pin_reg   <= '0;
        end else begin
            state_reg <= state_next;
            byte_reg  <= byte_next;
            pin_reg   <= pin_next;
        end
    end

endmodule

/* src/lcdseq_dpath.sv */
// ----------------------------------------------------------------------------
// lcdseq_dpath
// Request registers, text column counter, pin state builder and output stage.
// ----------------------------------------------------------------------------
module lcdseq_dpath
    import lcdseq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  ctrl_cmd_t           cmd,
    output dp_status_t          status,
    input  logic [CMD_W-1:0]    in_command,
    input  logic [BYTE_W-1:0]   in_byte_value,
    input  logic                in_text_start,
    input  logic [TICK_W-1:0]   setup_ticks,
    input  logic [TICK_W-1:0]   pulse_ticks,
    input  logic [TICK_W-1:0]   command_settle_ticks,
    input  logic [TICK_W-1:0]   data_settle_ticks,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [NIBBLE_W-1:0] out_nibble,
    output logic                out_rs,
    output logic                out_enable,
    output logic [TICK_W-1:0]   out_hold,
    output logic                out_last
);

    logic [CMD_W-1:0]    kind_reg;
    logic [BYTE_W-1:0]   value_reg;
    logic                wrap_reg;
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_eff;
    logic                valid_reg;
    logic [NIBBLE_W-1:0] nibble_reg;
    logic                rs_reg;
    logic                enable_reg;
    logic [TICK_W-1:0]   hold_reg;
    logic                last_reg;

    logic [BYTE_W-1:0]   cur_byte;
    logic                cur_rs;
    logic [NIBBLE_W-1:0] cur_nibble;
    logic                cur_enable;
    logic [TICK_W-1:0]   cur_hold;

    assign col_eff = in_text_start ? '0 : col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else if (cmd.load && (in_command == CMD_TEXT)) begin
            // Counter stops one past the wrap column until the next string.
            if (col_eff <= WRAP_COLUMN) begin
                col_reg <= col_eff + 5'd1;
            end else begin
                col_reg <= col_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg  <= in_command;
            value_reg <= in_byte_value;
            wrap_reg  <= (in_command == CMD_TEXT) && (col_eff == WRAP_COLUMN);
        end
    end

    always_comb begin
        cur_rs = 1'b0;
        case (kind_reg)
            CMD_INIT:   cur_byte = init_byte(cmd.byte_idx);
            CMD_BYTE:   cur_byte = value_reg;
            CMD_CURSOR: cur_byte = CURSOR_CMD | value_reg;
            CMD_TEXT: begin
                if (wrap_reg && (cmd.byte_idx == 3'd0)) begin
                    cur_byte = CURSOR_CMD | SECOND_LINE_ADDRESS;
                end else begin
                    cur_byte = value_reg;
                    cur_rs   = 1'b1;
                end
            end
            default:    cur_byte = value_reg;
        endcase
    end

    always_comb begin
        cur_nibble = (cmd.pin_idx < PIN_LO_SETUP) ? cur_byte[7:4] : cur_byte[3:0];
        cur_enable = (cmd.pin_idx == PIN_HI_PULSE) || (cmd.pin_idx == PIN_LO_PULSE);
        case (cmd.pin_idx)
            PIN_HI_PULSE, PIN_LO_PULSE: cur_hold = pulse_ticks;
            PIN_LO_SETTLE: cur_hold = cur_rs ? data_settle_ticks : command_settle_ticks;
            default:       cur_hold = setup_ticks;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            nibble_reg <= cur_nibble;
            rs_reg     <= cur_rs;
            enable_reg <= cur_enable;
            hold_reg   <= cur_hold;
            last_reg   <= cmd.last;
        end
    end

    assign status.out_free = !valid_reg || out_ready;
    assign status.is_init  = (kind_reg == CMD_INIT);
    assign status.wrap     = wrap_reg;

    assign out_valid  = valid_reg;
    assign out_nibble = nibble_reg;
    assign out_rs     = rs_reg;
    assign out_enable = enable_reg;
    assign out_hold   = hold_reg;
    assign out_last   = last_reg;

endmodule
